// ===== rtl/csm_pkg.sv =====
// ---------------------------------------------------------------------------
// csm_pkg: shared types and constants for the channel softmax unit
// Holds the vector depth, score width, exponent table and control structs.
// ---------------------------------------------------------------------------
package csm_pkg;

    localparam int Channels   = 64;
    localparam int ScoreBits  = 16;
    localparam int IdxBits    = $clog2(Channels);
    localparam int CntBits    = $clog2(Channels + 1);
    localparam int SumBits    = IdxBits + 17;
    localparam int NumBits    = 32;
    localparam int DivSteps   = NumBits;
    localparam int StepBits   = $clog2(DivSteps + 1);
    localparam logic [16:0] Log2eQ16 = 17'd94548;

    // Table of round(32768 * 2^(-k/16)) for k = 0..16.
    function automatic logic [15:0] pow2_tab(input logic [4:0] k);
        logic [15:0] v;
        begin
            case (k)
                5'd0:  v = 16'd32768;
                5'd1:  v = 16'd31379;
                5'd2:  v = 16'd30048;
                5'd3:  v = 16'd28774;
                5'd4:  v = 16'd27554;
                5'd5:  v = 16'd26386;
                5'd6:  v = 16'd25268;
                5'd7:  v = 16'd24196;
                5'd8:  v = 16'd23170;
                5'd9:  v = 16'd22188;
                5'd10: v = 16'd21247;
                5'd11: v = 16'd20347;
                5'd12: v = 16'd19484;
                5'd13: v = 16'd18658;
                5'd14: v = 16'd17867;
                5'd15: v = 16'd17109;
                default: v = 16'd16384;
            endcase
            return v;
        end
    endfunction

    // Sequencer states.
    typedef enum logic [6:0] {
        S_LOAD = 7'b0000001,
        S_EXP1 = 7'b0000010,
        S_EXP2 = 7'b0000100,
        S_EXP3 = 7'b0001000,
        S_DIVS = 7'b0010000,
        S_DIVR = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    // Divider request and response.
    typedef struct packed {
        logic                start;
        logic [NumBits-1:0]  num;
        logic [SumBits-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [NumBits-1:0]  quot;
    } t_div_rsp;

endpackage

// ===== rtl/csm_exp.sv =====
// ---------------------------------------------------------------------------
// csm_exp: exponential approximation in three steps, the first two registered
// Computes exp(-d) in Q1.15 from a Q5.12 distance below the maximum.
// ---------------------------------------------------------------------------
module csm_exp import csm_pkg::*; (
    input  logic                 i_clk,
    input  logic [ScoreBits:0]   i_dist,
    output logic [15:0]          o_exp
);

    logic [ScoreBits+17:0] r_t;
    logic [15:0]           r_v;
    logic [ScoreBits+5:0]  r_ip;
    logic [ScoreBits+17:0] n_t;
    logic [15:0]           n_v;
    logic [11:0]           f;
    logic [15:0]           ta;
    logic [15:0]           tb;
    logic [24:0]           corr;
    logic [16:0]           sum;

    // Step one: scale by log2(e).
    assign n_t = ((ScoreBits+18)'(i_dist) * (ScoreBits+18)'(Log2eQ16)
                 + (ScoreBits+18)'(32768)) >> 16;

    // Step two: table interpolation on the fraction.
    assign f    = r_t[11:0];
    assign ta   = pow2_tab({1'b0, f[11:8]});
    assign tb   = pow2_tab(5'({1'b0, f[11:8]} + 5'd1));
    assign corr = (25'(ta - tb) * 25'(f[7:0]) + 25'd128) >> 8;
    assign n_v  = ta - corr[15:0];

    always_ff @(posedge i_clk) begin
        r_t  <= n_t;
        r_v  <= n_v;
        r_ip <= r_t[ScoreBits+17:12];
    end

    // Step three: integer power shift with rounding.
    assign sum = {1'b0, r_v} + ((r_ip == '0) ? 17'd0 : (17'd1 << (r_ip[3:0] - 4'd1)));
    always_comb begin
        if (r_ip >= (ScoreBits+6)'(16)) begin
            o_exp = '0;
        end else if (r_ip == '0) begin
            o_exp = r_v;
        end else begin
            o_exp = 16'(sum >> r_ip[3:0]);
        end
    end

endmodule

// ===== rtl/csm_div.sv =====
// ---------------------------------------------------------------------------
// csm_div: shared restoring divider
// Produces one quotient bit per busy cycle for probability normalization.
// ---------------------------------------------------------------------------
module csm_div import csm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [NumBits-1:0]  r_q;
    logic [SumBits:0]    r_rem;
    logic [SumBits-1:0]  r_den;
    logic [StepBits-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [SumBits:0]    trial;
    logic [SumBits:0]    shifted;

    assign shifted = {r_rem[SumBits-1:0], r_q[NumBits-1]};
    assign trial   = shifted - {1'b0, r_den};

    // One quotient bit each cycle while busy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= StepBits'(DivSteps);
            end else if (r_busy) begin
                r_cnt  <= r_cnt - 1'b1;
                r_busy <= (r_cnt != StepBits'(1));
                r_done <= (r_cnt == StepBits'(1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            if (!trial[SumBits]) begin
                r_rem <= trial;
                r_q   <= {r_q[NumBits-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_q   <= {r_q[NumBits-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// ===== rtl/channel_softmax_unit.sv =====
// ---------------------------------------------------------------------------
// channel_softmax_unit: softmax over the channel scores of one position
// Stores scores, computes exponentials and normalized probabilities.
// ---------------------------------------------------------------------------
// Usage: scores enter on the s_axis beats, one Q4.12 value per beat, the
// last of a vector marked by s_axis_tlast. Up to 64 scores are stored;
// further scores are dropped and flag the vector's results as truncated.
// Loading takes a score on every beat offered. After the last beat the
// block runs an exponential pass over the scores through one three-step
// unit, then one division per score through a shared bit-serial divider
// of 32 steps, framed by the memory read, the start, the completion and
// the output beat of each probability. Results leave on m_axis in input
// order, tlast on the final one, tuser the truncation flag. s_axis_tready
// is low from the last beat until the final probability is taken. A stall
// on m_axis holds the current beat and the sequencer. Reset empties the
// vector and returns to loading.
// ---------------------------------------------------------------------------
module channel_softmax_unit import csm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] score
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] probability
    output logic        m_axis_tlast,   // final_res
    output logic        m_axis_tuser    // [0] truncated
);

    logic [ScoreBits-1:0] score_mem [Channels];
    logic [15:0]          exp_mem [Channels];
    t_state               r_state;
    logic [CntBits-1:0]   r_count;
    logic [IdxBits-1:0]   r_idx;
    logic signed [ScoreBits-1:0] r_max;
    logic [SumBits-1:0]   r_total;
    logic                 r_ovf;
    logic [ScoreBits-1:0] r_rd_score;
    logic [15:0]          r_rd_exp;
    logic [1:0]           r_wait;
    logic [ScoreBits:0]   r_dist;
    logic [15:0]          exp_val;
    logic                 r_ovalid;
    logic [15:0]          r_odata;
    logic                 r_olast;
    t_div_req             div_req;
    t_div_rsp             div_rsp;
    logic                 acc_in;
    logic                 last_idx;
    logic signed [ScoreBits-1:0] in_score;

    assign in_score      = s_axis_tdata[ScoreBits-1:0];
    assign s_axis_tready = (r_state == S_LOAD);
    assign acc_in        = s_axis_tvalid && s_axis_tready;
    assign last_idx      = ({1'b0, r_idx} == CntBits'(r_count - 1'b1));

    csm_exp u_exp (
        .i_clk  (i_clk),
        .i_dist (r_dist),
        .o_exp  (exp_val)
    );

    csm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign div_req.start = (r_state == S_DIVS) && (r_wait == 2'd1);
    assign div_req.num   = {r_rd_exp, 16'd0} + NumBits'(r_total >> 1);
    assign div_req.den   = r_total;

    // Memories: registered reads.
    always_ff @(posedge i_clk) begin
        if (acc_in && (r_count < CntBits'(Channels))) begin
            score_mem[r_count[IdxBits-1:0]] <= in_score;
        end
        if (r_state == S_EXP3 && r_wait == 2'd2) begin
            exp_mem[r_idx] <= exp_val;
        end
        r_rd_score <= score_mem[r_idx];
        r_rd_exp   <= exp_mem[r_idx];
        r_dist     <= {r_max[ScoreBits-1], r_max}
                      - {r_rd_score[ScoreBits-1], r_rd_score};
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_idx    <= '0;
            r_max    <= {1'b1, {(ScoreBits-1){1'b0}}};
            r_total  <= '0;
            r_ovf    <= 1'b0;
            r_wait   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (acc_in) begin
                        if (r_count < CntBits'(Channels)) begin
                            r_count <= r_count + 1'b1;
                            if (in_score > r_max) begin
                                r_max <= in_score;
                            end
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_state <= S_EXP1;
                            r_idx   <= '0;
                            r_total <= '0;
                            r_wait  <= '0;
                        end
                    end
                end
                S_EXP1: begin
                    // Score read lands, then distance register.
                    if (r_wait == 2'd1) begin
                        r_state <= S_EXP2;
                        r_wait  <= '0;
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                S_EXP2: begin
                    r_state <= S_EXP3;
                end
                S_EXP3: begin
                    if (r_wait == 2'd2) begin
                        r_total <= r_total + SumBits'(exp_val);
                        r_wait  <= '0;
                        if (last_idx) begin
                            r_idx   <= '0;
                            r_state <= S_DIVS;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_EXP1;
                        end
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                S_DIVS: begin
                    // Wait for the exponential read, then start the divider.
                    if (r_wait == 2'd1) begin
                        r_wait  <= '0;
                        r_state <= S_DIVR;
                    end else begin
                        r_wait <= r_wait + 1'b1;
                    end
                end
                S_DIVR: begin
                    if (div_rsp.done) begin
                        r_state  <= S_OUT;
                        r_ovalid <= 1'b1;
                        r_odata  <= (div_rsp.quot > 32'd65535) ? 16'hFFFF
                                                               : div_rsp.quot[15:0];
                        r_olast  <= last_idx;
                    end
                end
                S_OUT: begin
                    if (m_axis_tvalid && m_axis_tready) begin
                        r_ovalid <= 1'b0;
                        if (r_olast) begin
                            r_state <= S_LOAD;
                            r_count <= '0;
                            r_max   <= {1'b1, {(ScoreBits-1){1'b0}}};
                            r_ovf   <= 1'b0;
                            r_idx   <= '0;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_DIVS;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ovf;

endmodule

// ===== rtl/csm_checker.sv =====
// ---------------------------------------------------------------------------
// csm_checker: port-level checks for the channel softmax unit
// Watches the handshakes and the sequencing of input and output beats.
// ---------------------------------------------------------------------------
module csm_checker import csm_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // Input and output never overlap: the block is busy while emitting.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result is pending");

    // A last input beat closes the input until the vector is emitted.
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input ready right after the last beat");

    // A stalled result holds its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // After the final beat the input reopens.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("input not ready after the final result");

endmodule

bind channel_softmax_unit csm_checker u_csm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb: self-checking bench for channel_softmax_unit
// Feeds score vectors on the input stream, predicts every probability with
// an independent fixed-point softmax and checks the output stream in order.
// ---------------------------------------------------------------------------
module tb;
    import csm_pkg::*;

    typedef struct {
        logic [15:0] prob;
        logic        fin;
        logic        trunc;
    } t_prob_beat;

    // Scoreboard: collects the scores of a vector and queues the expected
    // probabilities once the last score is taken.
    class softmax_board;
        logic signed [15:0] scores[$];
        logic signed [15:0] peak;
        bit                 dropped;
        t_prob_beat         pending[$];
        int                 errors;

        function new();
            peak    = 16'sh8000;
            dropped = 0;
            errors  = 0;
        endfunction

        function logic [15:0] approx_exp(logic [16:0] d);
            logic [15:0] tab[17];
            logic [63:0] t;
            logic [63:0] ip;
            logic [11:0] f;
            logic [31:0] v;
            logic [31:0] tk;
            logic [31:0] tk1;
            tab = '{32768, 31379, 30048, 28774, 27554, 26386, 25268, 24196,
                    23170, 22188, 21247, 20347, 19484, 18658, 17867, 17109, 16384};
            t   = (64'(d) * 64'd94548 + 64'd32768) >> 16;
            ip  = t >> 12;
            f   = t[11:0];
            tk  = tab[f[11:8]];
            tk1 = tab[f[11:8] + 1];
            v   = tk - (((tk - tk1) * f[7:0] + 32'd128) >> 8);
            if (ip >= 16) return 16'd0;
            if (ip == 0) return v[15:0];
            v = (v + (32'd1 << (ip - 1))) >> ip;
            return v[15:0];
        endfunction

        function void note_score(logic [15:0] raw, logic lst);
            logic [15:0] ex[$];
            logic [63:0] total;
            logic [63:0] p;
            t_prob_beat  b;
            if (scores.size() < Channels) begin
                scores = {scores, raw};
                if ($signed(raw) > peak) peak = raw;
            end else begin
                dropped = 1;
            end
            if (!lst) return;
            total = 0;
            foreach (scores[i]) begin
                ex = {ex, approx_exp(17'(int'(peak) - int'(scores[i])))};
                total += ex[i];
            end
            foreach (ex[i]) begin
                p = ((64'(ex[i]) << 16) + (total >> 1)) / total;
                b.prob  = (p > 65535) ? 16'hFFFF : p[15:0];
                b.fin   = (i == ex.size() - 1);
                b.trunc = dropped;
                pending = {pending, b};
            end
            scores.delete();
            peak    = 16'sh8000;
            dropped = 0;
        endfunction

        function void check_prob(logic [15:0] prob, logic fin, logic trunc);
            t_prob_beat e;
            if (pending.size() == 0) begin
                $error("unexpected probability beat %0d", prob);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (prob !== e.prob) begin
                $error("probability: expected %0d, got %0d", e.prob, prob);
                errors++;
            end
            if (fin !== e.fin) begin
                $error("final_res: expected %0d, got %0d", e.fin, fin);
                errors++;
            end
            if (trunc !== e.trunc) begin
                $error("truncated: expected %0d, got %0d", e.trunc, trunc);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 0;   // [15:0] score
    logic        s_axis_tlast = 0;   // last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [15:0] m_axis_tdata;       // [15:0] probability
    logic        m_axis_tlast;       // final_res
    logic        m_axis_tuser;       // [0] truncated

    softmax_board board = new();
    bit           calm = 0;      // no idling near the end
    int           hold_cycles = 0;
    int           cycle_count = 0;

    channel_softmax_unit DUT (.*);

    always #5 i_clk = ~i_clk;

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Check every accepted output beat.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_prob(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    // Receiver: random stalls, plus a long hold when requested.
    initial begin : receiver
        int n;
        @(posedge i_clk);
        m_axis_tready <= 1;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                m_axis_tready <= 1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 17);
                m_axis_tready <= 0;
                repeat (n) @(posedge i_clk);
                m_axis_tready <= 1;
            end
        end
    end

    // Offer one score beat and wait until it is taken. The valid stays up
    // afterwards, so the next beat follows with no gap but for a random pause.
    task automatic send_score(logic [15:0] sc, logic lst);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= sc;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_score(sc, lst);
    endtask

    task automatic send_vector(int len, int mode);
        logic [15:0] sc;
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: sc = 16'($urandom());
                1: sc = 16'($urandom_range(0, 2000)) - 16'd1000;
                default: sc = (i % 2) ? 16'h7FFF : 16'h8000;
            endcase
            send_score(sc, i == len - 1);
        end
    endtask

    // Stop offering and wait until every expected result has come.
    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int len;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: single score, extremes, equal scores, mixed signs.
        send_score(16'h7FFF, 1);
        send_score(16'h8000, 1);
        send_vector(2, 2);
        send_score(16'h0000, 0);
        send_score(16'h0000, 1);
        send_score(16'h1000, 0);
        send_score(16'h0000, 0);
        send_score(16'hF000, 0);
        send_score(16'hFFFF, 1);
        drain();

        // Over-full vector with the last flag on a dropped score; the
        // receiver holds off so the output backs up into the input while
        // the next vectors are already offered.
        hold_cycles = 3000;
        send_vector(Channels + 3, 1);

        // Random short vectors.
        for (int v = 0; v < 8; v++) begin
            len = $urandom_range(1, 6);
            if (v > 5) calm = 1;
            send_vector(len, $urandom_range(0, 1));
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/csm_pkg.sv
rtl/csm_exp.sv
rtl/csm_div.sv
rtl/channel_softmax_unit.sv
rtl/csm_checker.sv
tb/tb.sv
